// File: rtl/packed_array_list_engine_macros.svh
`ifndef PACKED_ARRAY_LIST_ENGINE_MACROS_SVH
`define PACKED_ARRAY_LIST_ENGINE_MACROS_SVH

// Checked on every clk edge outside reset.
`define PALE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clk edge, reset included.
`define PALE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pale_pkg.sv
`timescale 1ns / 1ps

package pale_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int DATA_W   = 32;
  localparam int REQ_W    = 2;
  localparam int POS_W    = 4;
  localparam int STAT_W   = 2;
  localparam int IDX_W    = 4;
  localparam int CNT_O_W  = 5;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd3;

endpackage

// File: rtl/packed_array_list_engine.sv
`timescale 1ns / 1ps
// Sequence: insert goes from accept straight to the result state; read passes a read wait;
//   search and remove read and compare entries in turn; remove then shifts later ones down.
// Throughput: one request at a time; the list store with its single read port and registered read
//   sets the pace of the scan and of the shift.
// Reset (rst_n, synchronous, active low) empties the list and sets capacity to 16;
//   entries are not cleared, the count alone bounds what may be read.
module packed_array_list_engine #(
  parameter int DEPTH = pale_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pale_pkg::CAP_W-1:0]          cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pale_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [pale_pkg::DATA_W-1:0]  in_value,
  input  logic [pale_pkg::POS_W-1:0]          in_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pale_pkg::STAT_W-1:0]         out_status,
  output logic [pale_pkg::IDX_W-1:0]          out_found_index,
  output logic signed [pale_pkg::DATA_W-1:0]  out_read_value,
  output logic [pale_pkg::CNT_O_W-1:0]        out_count
);
  import pale_pkg::*;

`include "packed_array_list_engine_macros.svh"

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN_RD   = 3'd1;
  localparam logic [2:0] S_SCAN_CMP  = 3'd2;
  localparam logic [2:0] S_SHIFT_RD  = 3'd3;
  localparam logic [2:0] S_SHIFT_WR  = 3'd4;
  localparam logic [2:0] S_READ_WAIT = 3'd5;
  localparam logic [2:0] S_DONE      = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [REQ_W-1:0]  req_r;
  logic [DATA_W-1:0] val_r;

  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_fidx_r, res_fidx_nxt;
  logic [DATA_W-1:0] res_rval_r, res_rval_nxt;

  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [IDX_W-1:0]   out_fidx_r;
  logic [DATA_W-1:0]  out_rval_r;
  logic [CNT_O_W-1:0] out_count_r;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  logic [CNT_W-1:0]  idx_inc, idx_inc2;
  logic              can_insert, pos_ok, hit, accept, push;

  pale_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign idx_inc    = idx_r + CNT_W'(1);
  assign idx_inc2   = idx_r + CNT_W'(2);
  assign can_insert = (EXT_W'(count_r) < EXT_W'(cap_r)) && (count_r < DEPTH_C);
  assign pos_ok     = EXT_W'(in_position) < EXT_W'(count_r);
  assign hit        = (mem_rdata == val_r);
  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign push       = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_fidx_nxt   = res_fidx_r;
    res_rval_nxt   = res_rval_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[AW-1:0];
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_status_nxt = STAT_OK;
          res_fidx_nxt   = '0;
          res_rval_nxt   = '0;
          idx_nxt        = '0;
          unique case (in_req_type) inside
            REQ_INSERT: begin
              if (can_insert) begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = in_value;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                res_status_nxt = STAT_FULL;
              end
              state_nxt = S_DONE;
            end
            REQ_REMOVE, REQ_SEARCH: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_NOT_FOUND;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            REQ_READ: begin
              if (pos_ok) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_position);
                state_nxt = S_READ_WAIT;
              end else begin
                res_status_nxt = STAT_BAD_POS;
                state_nxt      = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (hit) begin
          if (req_r == REQ_SEARCH) begin
            res_fidx_nxt = IDX_W'(idx_r);
            state_nxt    = S_DONE;
          end else if (idx_inc < count_r) begin
            state_nxt = S_SHIFT_RD;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_DONE;
          end
        end else if (idx_inc == count_r) begin
          res_status_nxt = STAT_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_inc[AW-1:0];
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        // entry idx+1 moves down into idx
        mem_we  = 1'b1;
        idx_nxt = idx_inc;
        if (idx_inc2 < count_r) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end
      S_READ_WAIT: begin
        res_rval_nxt = mem_rdata;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_fidx_r   <= res_fidx_nxt;
    res_rval_r   <= res_rval_nxt;
    if (accept) begin
      req_r <= in_req_type;
      val_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_status_r <= res_status_r;
      out_fidx_r   <= res_fidx_r;
      out_rval_r   <= res_rval_r;
      out_count_r  <= CNT_O_W'(count_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_fidx_r;
  assign out_read_value  = out_rval_r;
  assign out_count       = out_count_r;

  `PALE_ASSERT(a_count_bound, count_r <= DEPTH_C, "entry count above depth")
  `PALE_ASSERT(a_count_step, $past(rst_n) && (count_r != $past(count_r)) |-> ((count_r == $past(count_r) + CNT_W'(1)) || (count_r + CNT_W'(1) == $past(count_r))), "count moved by more than one")
  `PALE_ASSERT(a_shift_in_list, (state_r == S_SHIFT_WR) |-> (idx_inc < count_r), "shift writes outside the list")
  `PALE_ASSERT(a_push_from_done, $rose(out_valid_r) |-> ($past(state_r) == S_DONE), "result raised outside done")

endmodule

// File: rtl/pale_mem.sv
`timescale 1ns / 1ps

module pale_mem #(
  parameter int DEPTH = pale_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(DEPTH)-1:0]    waddr,
  input  logic [pale_pkg::DATA_W-1:0] wdata,
  input  logic                        re,
  input  logic [$clog2(DEPTH)-1:0]    raddr,
  output logic [pale_pkg::DATA_W-1:0] rdata
);
  import pale_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
